[rtl/msk_pkg.sv]
// Shared constants and types for the minimum-tracking stack.
// Used by the RAM wrapper's users, the sequencer, the top level and the checker.
// Depends on nothing.
package msk_pkg;

	// Stack capacity and derived widths.
	localparam int DEPTH  = 1024;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = ADDR_W + 1;
	localparam int DATA_W = 32;

	// Result transaction: top, minimum, empty flag and depth, padded to whole bytes.
	localparam int RSP_RAW_W = 2 * DATA_W + 1 + CNT_W;
	localparam int RSP_DATA_W = ((RSP_RAW_W + 7) / 8) * 8;

	// Operation codes.
	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef logic signed [DATA_W-1:0] word_t;

	// One result as handed from the sequencer to the output register.
	typedef struct packed {
		logic [1:0]       status;
		logic [CNT_W-1:0] depth;
		logic             is_empty;
		word_t            min_value;
		word_t            top_value;
	} rsp_t;

endpackage

[rtl/msk_ram.sv]
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// Generic; depends on nothing.
module msk_ram #(
	parameter int ADDR_W = 10,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[rtl/msk_ctrl.sv]
// Sequencer of the minimum-tracking stack: counts, cached tops and the two stack memories.
// Depends on msk_pkg and msk_ram.
module msk_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [1:0]         opcode,
	input  msk_pkg::word_t     push_value,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output msk_pkg::rsp_t      rsp
);

	localparam int CNT_W  = msk_pkg::CNT_W;
	localparam int ADDR_W = msk_pkg::ADDR_W;

	localparam logic [1:0] SM_IDLE  = 2'd0;
	localparam logic [1:0] SM_FETCH = 2'd1;
	localparam logic [1:0] SM_RESP  = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] vcount_q;
	logic [CNT_W-1:0] mcount_q;
	msk_pkg::word_t   top_q;
	msk_pkg::word_t   mtop_q;
	logic [1:0]       status_q;

	logic             accept;
	logic             vfull;
	logic             vempty;
	logic             mempty;
	logic             mfull;
	logic             min_take;
	logic             min_drop;
	logic [CNT_W-1:0] mcount_pop;
	logic [CNT_W-1:0] vrd_idx;
	logic [CNT_W-1:0] mrd_idx;
	logic             vwe;
	logic             mwe;
	logic [msk_pkg::DATA_W-1:0] vrdata;
	logic [msk_pkg::DATA_W-1:0] mrdata;
	msk_pkg::word_t   cur_top;
	msk_pkg::word_t   cur_mtop;

	assign req_ready = (state_q == SM_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = (state_q == SM_FETCH) || (state_q == SM_RESP);

	// Occupancy tests and the minimum-history decisions.
	assign vfull    = (vcount_q == CNT_W'(msk_pkg::DEPTH));
	assign vempty   = (vcount_q == '0);
	assign mempty   = (mcount_q == '0);
	assign mfull    = (mcount_q == CNT_W'(msk_pkg::DEPTH));
	assign min_take = (mempty || (push_value <= mtop_q)) && !mfull;
	assign min_drop = !mempty && (top_q == mtop_q);
	assign mcount_pop = min_drop ? (mcount_q - CNT_W'(1)) : mcount_q;

	// A pop reads the entries that become the new tops.
	assign vrd_idx = vcount_q - CNT_W'(2);
	assign mrd_idx = mcount_pop - CNT_W'(1);

	assign vwe = accept && (opcode == msk_pkg::OP_PUSH) && !vfull;
	assign mwe = vwe && min_take;

	msk_ram #(
		.ADDR_W(ADDR_W),
		.DATA_W(msk_pkg::DATA_W)
	) u_value_ram (
		.clk  (clk),
		.we   (vwe),
		.waddr(vcount_q[ADDR_W-1:0]),
		.wdata(push_value),
		.raddr(vrd_idx[ADDR_W-1:0]),
		.rdata(vrdata)
	);

	msk_ram #(
		.ADDR_W(ADDR_W),
		.DATA_W(msk_pkg::DATA_W)
	) u_min_ram (
		.clk  (clk),
		.we   (mwe),
		.waddr(mcount_q[ADDR_W-1:0]),
		.wdata(push_value),
		.raddr(mrd_idx[ADDR_W-1:0]),
		.rdata(mrdata)
	);

	// Control state: sequencer and counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= SM_IDLE;
			vcount_q <= '0;
			mcount_q <= '0;
		end else begin
			case (state_q)
				SM_IDLE: begin
					if (accept) begin
						state_q <= SM_RESP;
						case (opcode)
							msk_pkg::OP_PUSH: begin
								if (!vfull) begin
									vcount_q <= vcount_q + CNT_W'(1);
									if (min_take) begin
										mcount_q <= mcount_q + CNT_W'(1);
									end
								end
							end
							msk_pkg::OP_POP: begin
								if (!vempty) begin
									vcount_q <= vcount_q - CNT_W'(1);
									mcount_q <= mcount_pop;
									state_q  <= SM_FETCH;
								end
							end
							default: begin
							end
						endcase
					end
				end
				SM_FETCH, SM_RESP: begin
					if (rsp_ready) begin
						state_q <= SM_IDLE;
					end else begin
						state_q <= SM_RESP;
					end
				end
				default: begin
					state_q <= SM_IDLE;
				end
			endcase
		end
	end

	// Cached tops of both stacks and the status of the transaction in flight.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= msk_pkg::ST_OK;
			case (opcode)
				msk_pkg::OP_PUSH: begin
					if (vfull) begin
						status_q <= msk_pkg::ST_FULL;
					end else begin
						top_q <= push_value;
						if (min_take) begin
							mtop_q <= push_value;
						end
					end
				end
				msk_pkg::OP_POP: begin
					if (vempty) begin
						status_q <= msk_pkg::ST_EMPTY;
					end
				end
				default: begin
				end
			endcase
		end else if (state_q == SM_FETCH) begin
			top_q  <= cur_top;
			mtop_q <= cur_mtop;
		end
	end

	// Right after a pop the new tops come straight from the memories.
	assign cur_top  = (state_q == SM_FETCH) ? msk_pkg::word_t'(vrdata) : top_q;
	assign cur_mtop = (state_q == SM_FETCH) ? msk_pkg::word_t'(mrdata) : mtop_q;

	// Result of the operation; an empty stack reads minus one.
	always_comb begin
		rsp.status    = status_q;
		rsp.depth     = vcount_q;
		rsp.is_empty  = vempty;
		rsp.top_value = vempty ? '1 : cur_top;
		rsp.min_value = (vempty || mempty) ? '1 : cur_mtop;
	end

endmodule

[rtl/min_tracking_stack.sv]
// Minimum-tracking stack: top level with the stream ports and the result register.
// Depends on msk_pkg and msk_ctrl.

// A stack of signed 32-bit values that also reports the smallest value it holds.
// Each input transaction (push, pop or read) yields exactly one result transaction
// giving the top, the minimum, the depth, an empty flag and a status. A push or a
// read updates the counts and cached tops, and a pop also reads the stack memories
// to fetch the new tops. One item is worked on at a time; a result left waiting at
// the output does not stop the next item being accepted, but that item's result
// waits for the output register to free. No clearing pass follows reset: only
// entries below the counts are ever used.
module min_tracking_stack (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// push_value [31:0]
	input  logic [msk_pkg::DATA_W-1:0]       s_axis_tdata,
	// opcode [1:0]
	input  logic [1:0]                       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// top_value [31:0], min_value [63:32], is_empty [64], depth [75:65], zero padding above
	output logic [msk_pkg::RSP_DATA_W-1:0]   m_axis_tdata,
	// status [1:0]
	output logic [1:0]                       m_axis_tuser
);

	localparam int PAD_W = msk_pkg::RSP_DATA_W - msk_pkg::RSP_RAW_W;

	logic          rsp_valid;
	logic          rsp_ready;
	msk_pkg::rsp_t rsp;
	logic          out_valid_q;
	logic [msk_pkg::RSP_DATA_W-1:0] out_data_q;
	logic [1:0]    out_user_q;

	msk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.opcode    (s_axis_tuser),
		.push_value(msk_pkg::word_t'(s_axis_tdata)),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// The output register takes a new result when empty or being drained.
	assign rsp_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_ready) begin
			out_valid_q <= rsp_valid;
		end
	end

	// Result payload, packed from the lowest bit up.
	always_ff @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			out_data_q <= {PAD_W'(0), rsp.depth, rsp.is_empty, rsp.min_value, rsp.top_value};
			out_user_q <= rsp.status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

[rtl/msk_chk.sv]
// Port-level checker for the minimum-tracking stack, bound to the top level.
// Depends on msk_pkg and min_tracking_stack.
module msk_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [msk_pkg::RSP_DATA_W-1:0] m_axis_tdata,
	input logic [1:0]                     m_axis_tuser
);

	localparam int TOP_LO = 0;
	localparam int MIN_LO = msk_pkg::DATA_W;
	localparam int EMP_B  = 2 * msk_pkg::DATA_W;
	localparam int DEP_LO = EMP_B + 1;

	logic [msk_pkg::DATA_W-1:0] top_f;
	logic [msk_pkg::DATA_W-1:0] min_f;
	logic                       empty_f;
	logic [msk_pkg::CNT_W-1:0]  depth_f;

	assign top_f   = m_axis_tdata[TOP_LO +: msk_pkg::DATA_W];
	assign min_f   = m_axis_tdata[MIN_LO +: msk_pkg::DATA_W];
	assign empty_f = m_axis_tdata[EMP_B];
	assign depth_f = m_axis_tdata[DEP_LO +: msk_pkg::CNT_W];

	// A stalled result transaction holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// One operation at a time: the input is not ready right after a transaction is accepted.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while an operation is in progress");

	// The empty flag agrees with the depth.
	a_empty_depth: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (empty_f == (depth_f == '0)))
		else $error("empty flag disagrees with depth");

	// An empty stack reads minus one for top and minimum.
	a_empty_reads: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && empty_f |-> (top_f == '1) && (min_f == '1))
		else $error("empty stack did not read minus one");

	// Depth never exceeds capacity and the status code is defined.
	a_depth_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (depth_f <= msk_pkg::CNT_W'(msk_pkg::DEPTH)) &&
			(m_axis_tuser == msk_pkg::ST_OK || m_axis_tuser == msk_pkg::ST_FULL ||
			 m_axis_tuser == msk_pkg::ST_EMPTY))
		else $error("depth or status out of range");

endmodule

bind min_tracking_stack msk_chk u_msk_chk (.*);

[tb/tb_min_tracking_stack.sv]
// Self-checking testbench for the minimum-tracking stack: drives push, pop and read
// transactions with random gaps and checks every result against a behavioural predictor.
// Depends on msk_pkg and the min_tracking_stack RTL.
module tb_min_tracking_stack;
	timeunit 1ns;
	timeprecision 1ps;

	// Opcode 3 has no name in the package; the block treats it as a read.
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct {
		logic [1:0]     op;
		msk_pkg::word_t value;
		bit             drain;
	} stack_req_t;

	logic                           clk;
	logic                           arst_n        = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [msk_pkg::DATA_W-1:0]     s_axis_tdata  = '0;
	logic [1:0]                     s_axis_tuser  = '0;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [msk_pkg::RSP_DATA_W-1:0] m_axis_tdata;
	logic [1:0]                     m_axis_tuser;

	// Predictor state: both stacks and their fill counts.
	msk_pkg::word_t value_mem [msk_pkg::DEPTH];
	msk_pkg::word_t min_mem [msk_pkg::DEPTH];
	int unsigned    value_cnt = 0;
	int unsigned    min_cnt   = 0;

	stack_req_t    req_q[$];
	msk_pkg::rsp_t snapshot_q[$];
	stack_req_t    cur_req;

	bit src_fire = 1'b0;
	bit snk_fire = 1'b0;
	bit next_valid;
	int src_wait = 0;
	int snk_wait = 0;
	int src_calm = 0;
	int snk_calm = 0;

	int errors    = 0;
	int checked   = 0;
	int n_push    = 0;
	int n_pop     = 0;
	int n_full    = 0;
	int n_underrun = 0;
	int max_depth = 0;

	min_tracking_stack dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Applies one operation to the predicted stacks and returns the view that follows.
	function automatic msk_pkg::rsp_t apply_stack_op(logic [1:0] op, msk_pkg::word_t val);
		msk_pkg::rsp_t r;
		r.status = msk_pkg::ST_OK;
		if (op == msk_pkg::OP_PUSH) begin
			n_push++;
			if (value_cnt >= msk_pkg::DEPTH) begin
				r.status = msk_pkg::ST_FULL;
				n_full++;
			end else begin
				value_mem[value_cnt] = val;
				value_cnt++;
				if (min_cnt == 0 || val <= min_mem[min_cnt-1]) begin
					if (min_cnt < msk_pkg::DEPTH) begin
						min_mem[min_cnt] = val;
						min_cnt++;
					end
				end
			end
		end else if (op == msk_pkg::OP_POP) begin
			n_pop++;
			if (value_cnt == 0) begin
				r.status = msk_pkg::ST_EMPTY;
				n_underrun++;
			end else begin
				if (min_cnt > 0 && value_mem[value_cnt-1] == min_mem[min_cnt-1])
					min_cnt--;
				value_cnt--;
			end
		end
		if (value_cnt == 0) begin
			r.top_value = -1;
			r.min_value = -1;
			r.is_empty  = 1'b1;
		end else begin
			r.top_value = value_mem[value_cnt-1];
			r.min_value = (min_cnt > 0) ? min_mem[min_cnt-1] : msk_pkg::word_t'(-1);
			r.is_empty  = 1'b0;
		end
		r.depth = value_cnt[msk_pkg::CNT_W-1:0];
		if (value_cnt > max_depth)
			max_depth = value_cnt;
		return r;
	endfunction

	// Idle cycles before the next transaction, with occasional stretches of none at all.
	function automatic int pick_gap(ref int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 31) == 0)
			calm = $urandom_range(10, 40);
		return $urandom_range(0, 5);
	endfunction

	// Values lean towards small numbers so that equal minima occur often.
	function automatic msk_pkg::word_t pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return -1;
			3: return 0;
			4, 5, 6: return msk_pkg::word_t'($urandom_range(0, 16)) - msk_pkg::word_t'(8);
			default: return msk_pkg::word_t'($urandom);
		endcase
	endfunction

	function automatic logic [1:0] pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return msk_pkg::OP_PUSH;
		else if (r < 85)
			return msk_pkg::OP_POP;
		else if (r < 95)
			return msk_pkg::OP_READ;
		return OP_SPARE;
	endfunction

	task automatic queue_op(logic [1:0] op, msk_pkg::word_t val, bit drain = 1'b0);
		stack_req_t it;
		it.op    = op;
		it.value = val;
		it.drain = drain;
		req_q.insert(req_q.size(), it);
	endtask

	// A mix of push runs, pop runs and single operations of any kind.
	task automatic queue_random_ops(int count);
		int made;
		int k;
		made = 0;
		while (made < count) begin
			case ($urandom_range(0, 3))
				0: begin
					k = $urandom_range(1, 12);
					repeat (k) queue_op(msk_pkg::OP_PUSH, pick_value());
				end
				1: begin
					k = $urandom_range(1, 12);
					repeat (k) queue_op(msk_pkg::OP_POP, msk_pkg::word_t'($urandom));
				end
				default: begin
					k = 1;
					queue_op(pick_op(), pick_value());
				end
			endcase
			made += k;
		end
	endtask

	// Handshake sampling and result checking at the rising edge.
	always @(posedge clk) begin
		msk_pkg::rsp_t got;
		msk_pkg::rsp_t want;
		src_fire <= s_axis_tvalid && s_axis_tready;
		snk_fire <= m_axis_tvalid && m_axis_tready;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.top_value = m_axis_tdata[msk_pkg::DATA_W-1:0];
			got.min_value = m_axis_tdata[2*msk_pkg::DATA_W-1:msk_pkg::DATA_W];
			got.is_empty  = m_axis_tdata[2*msk_pkg::DATA_W];
			got.depth     = m_axis_tdata[2*msk_pkg::DATA_W+msk_pkg::CNT_W:2*msk_pkg::DATA_W+1];
			got.status    = m_axis_tuser;
			if (snapshot_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result transaction: top=%0d min=%0d empty=%0b",
					$time, got.top_value, got.min_value, got.is_empty);
				$display("%0t:           depth=%0d status=%0d", $time, got.depth, got.status);
			end else begin
				want = snapshot_q.pop_front();
				checked++;
				if (got !== want) begin
					errors++;
					$display("%0t: mismatch: expected top=%0d min=%0d empty=%0b depth=%0d status=%0d",
						$time, want.top_value, want.min_value, want.is_empty, want.depth,
						want.status);
					$display("%0t:           actual   top=%0d min=%0d empty=%0b depth=%0d status=%0d",
						$time, got.top_value, got.min_value, got.is_empty, got.depth,
						got.status);
				end
			end
		end
	end

	// Source side: presents queued transactions and predicts each one as it is taken.
	always @(negedge clk) begin
		if (arst_n) begin
			next_valid = s_axis_tvalid;
			if (src_fire) begin
				cur_req = req_q.pop_front();
				snapshot_q.insert(snapshot_q.size(), apply_stack_op(cur_req.op, cur_req.value));
				src_wait   = pick_gap(src_calm);
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (src_wait > 0) begin
					src_wait--;
				end else if (req_q.size() > 0 &&
						!(req_q[0].drain && snapshot_q.size() > 0)) begin
					s_axis_tuser <= req_q[0].op;
					s_axis_tdata <= req_q[0].value;
					next_valid   = 1'b1;
				end
			end
			s_axis_tvalid <= next_valid;
		end
	end

	// Sink side: stalls for a random number of cycles after each result.
	always @(negedge clk) begin
		if (arst_n) begin
			if (snk_fire)
				snk_wait = pick_gap(snk_calm);
			if (snk_wait > 0) begin
				snk_wait--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Stimulus, then the wait for the last results and the verdict.
	initial begin
		// Empty-stack reads, underruns and the spare opcode first.
		queue_op(msk_pkg::OP_READ, 0);
		queue_op(msk_pkg::OP_POP, 32'sh7fff_ffff);
		queue_op(OP_SPARE, -1);
		// Extremes, equal minima and a held value of -1.
		queue_op(msk_pkg::OP_PUSH, 32'sh7fff_ffff);
		queue_op(msk_pkg::OP_PUSH, 32'sh8000_0000);
		queue_op(msk_pkg::OP_PUSH, 32'sh8000_0000);
		queue_op(msk_pkg::OP_PUSH, -1);
		queue_op(msk_pkg::OP_PUSH, 0);
		queue_op(msk_pkg::OP_READ, 32'sh5555_5555);
		queue_op(OP_SPARE, 32'shaaaa_aaaa);
		queue_op(msk_pkg::OP_POP, 0);
		queue_op(msk_pkg::OP_POP, 0);
		queue_op(msk_pkg::OP_POP, 0);
		queue_op(msk_pkg::OP_POP, 0);
		queue_op(msk_pkg::OP_READ, 0);
		queue_op(msk_pkg::OP_POP, 0);
		queue_op(msk_pkg::OP_POP, 0);
		// A larger value above the minimum must not disturb it when popped.
		queue_op(msk_pkg::OP_PUSH, 5);
		queue_op(msk_pkg::OP_PUSH, 3);
		queue_op(msk_pkg::OP_PUSH, 3);
		queue_op(msk_pkg::OP_PUSH, 9);
		queue_op(msk_pkg::OP_POP, 0);
		queue_op(msk_pkg::OP_POP, 0);
		queue_op(msk_pkg::OP_POP, 0);
		queue_op(msk_pkg::OP_POP, 0);

		queue_random_ops(200);

		// Hold off until the block has answered everything, then build a deep stack
		// and unwind it with four more pops than pushes.
		queue_op(msk_pkg::OP_READ, 0, 1'b1);
		repeat (100) queue_op(msk_pkg::OP_PUSH, pick_value());
		queue_op(msk_pkg::OP_READ, 0);
		repeat (104) queue_op(msk_pkg::OP_POP, 0);

		queue_random_ops(55);
		queue_op(msk_pkg::OP_READ, 0, 1'b1);
		queue_random_ops(55);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (req_q.size() != 0 || s_axis_tvalid)
			@(negedge clk);
		while (snapshot_q.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("Checked %0d results: %0d pushes (%0d refused as full), %0d pops (%0d on empty).",
			checked, n_push, n_full, n_pop, n_underrun);
		$display("Greatest depth reached %0d of %0d; %0d mismatches.",
			max_depth, msk_pkg::DEPTH, errors);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Guard against a hang anywhere in the run.
	initial begin
		#20_000_000;
		$display("Timed out with %0d results still awaited.", snapshot_q.size());
		$display("simulation failed");
		$finish;
	end

endmodule

[sim.f]
rtl/msk_pkg.sv
rtl/msk_ram.sv
rtl/msk_ctrl.sv
rtl/min_tracking_stack.sv
rtl/msk_chk.sv
tb/tb_min_tracking_stack.sv
